// ===== sv/mcaf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcaf_pkg
// Shared types, codes and constants of the motion command ASCII framer.
// ----------------------------------------------------------------------------
package mcaf_pkg;

  // Command selector codes carried on the input tuser.
  localparam logic [1:0] OP_LINEAR  = 2'd0;
  localparam logic [1:0] OP_ANGULAR = 2'd1;
  localparam logic [1:0] OP_GOAL    = 2'd2;

  // Field widths.
  localparam int VAL_W  = 18;
  localparam int GOAL_W = 10;
  localparam int REM_W  = 17;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 3;
  localparam int EXP_W  = 3;

  // Frame characters.
  localparam logic [BYTE_W-1:0] CH_LIN_POS  = 8'h6C; // l
  localparam logic [BYTE_W-1:0] CH_LIN_NEG  = 8'h4C; // L
  localparam logic [BYTE_W-1:0] CH_ANG_POS  = 8'h61; // a
  localparam logic [BYTE_W-1:0] CH_ANG_NEG  = 8'h41; // A
  localparam logic [BYTE_W-1:0] CH_GOAL     = 8'h47; // G
  localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;
  localparam logic [BYTE_W-1:0] DIGIT_BASE  = 8'd48;

  // Frame positions.
  localparam logic [POS_W-1:0] POS_LETTER     = 3'd0;
  localparam logic [POS_W-1:0] POS_GOAL_SPLIT = 3'd3;
  localparam logic [POS_W-1:0] POS_LAST       = 3'd6;

  // Leading decimal exponents and wrap limits.
  localparam logic [EXP_W-1:0] EXP_SPEED = 3'd4;
  localparam logic [EXP_W-1:0] EXP_GOAL  = 3'd2;
  localparam logic [VAL_W-1:0]  MAG_WRAP  = 18'd100000;
  localparam logic [GOAL_W-1:0] GOAL_WRAP = 10'd1000;

  // Default depth of the command queue.
  localparam int QUEUE_DEPTH_DEF = 2;

  // One classified command waiting for the byte emitter.
  typedef struct packed {
    logic [BYTE_W-1:0] letter;
    logic              goal;
    logic [REM_W-1:0]  rem;
    logic [GOAL_W-1:0] alt;
  } entry_t;

  // Power of ten for a digit exponent.
  function automatic logic [REM_W-1:0] pow10(input logic [EXP_W-1:0] e);
    logic [REM_W-1:0] p;
    case (e)
      3'd4:    p = 17'd10000;
      3'd3:    p = 17'd1000;
      3'd2:    p = 17'd100;
      3'd1:    p = 17'd10;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mcaf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcaf_front
// Accepts commands, drops unchanged speed values, and builds queue entries
// with the sign letter and the wrapped magnitudes.
// ----------------------------------------------------------------------------
module mcaf_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [39:0]                in_tdata,   // command_value, goal_x, goal_y
  input  wire logic [1:0]                 in_tuser,   // op
  input  wire logic                       q_full,
  output logic                            q_push,
  output mcaf_pkg::entry_t                q_entry
);
  import mcaf_pkg::*;

  logic [VAL_W-1:0]  last_lin_r, last_lin_nxt;
  logic [VAL_W-1:0]  last_ang_r, last_ang_nxt;
  logic [VAL_W-1:0]  raw, mag, mag_wrap;
  logic [GOAL_W-1:0] gx, gy, gx_wrap, gy_wrap;
  logic              neg, accept, emit;

  assign raw = in_tdata[VAL_W-1:0];
  assign gx  = in_tdata[VAL_W+GOAL_W-1:VAL_W];
  assign gy  = in_tdata[VAL_W+2*GOAL_W-1:VAL_W+GOAL_W];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Magnitude of the two's complement value, folded below one hundred thousand.
  assign neg      = raw[VAL_W-1];
  assign mag      = neg ? (VAL_W'(0) - raw) : raw;
  assign mag_wrap = (mag >= MAG_WRAP) ? (mag - MAG_WRAP) : mag;
  assign gx_wrap  = (gx >= GOAL_WRAP) ? (gx - GOAL_WRAP) : gx;
  assign gy_wrap  = (gy >= GOAL_WRAP) ? (gy - GOAL_WRAP) : gy;

  // Classify the word and decide whether it produces a frame.
  always_comb begin
    emit         = 1'b0;
    last_lin_nxt = last_lin_r;
    last_ang_nxt = last_ang_r;
    q_entry      = '0;
    case (in_tuser)
      OP_LINEAR: begin
        emit          = (raw != last_lin_r);
        q_entry.letter = neg ? CH_LIN_NEG : CH_LIN_POS;
        q_entry.rem    = mag_wrap[REM_W-1:0];
        if (accept) begin
          last_lin_nxt = raw;
        end
      end
      OP_ANGULAR: begin
        emit          = (raw != last_ang_r);
        q_entry.letter = neg ? CH_ANG_NEG : CH_ANG_POS;
        q_entry.rem    = mag_wrap[REM_W-1:0];
        if (accept) begin
          last_ang_nxt = raw;
        end
      end
      OP_GOAL: begin
        emit           = 1'b1;
        q_entry.letter = CH_GOAL;
        q_entry.goal   = 1'b1;
        q_entry.rem    = REM_W'(gx_wrap);
        q_entry.alt    = gy_wrap;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign q_push = accept && emit;

  // Last values sent on each speed channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_lin_r <= '0;
      last_ang_r <= '0;
    end else begin
      last_lin_r <= last_lin_nxt;
      last_ang_r <= last_ang_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mcaf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcaf_queue
// Small first-in first-out queue of command entries between the front and
// the byte emitter.
// ----------------------------------------------------------------------------
module mcaf_queue #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mcaf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcaf_back
// Byte emitter: takes one queued command and sends its seven frame bytes,
// extracting one decimal digit per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module mcaf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire mcaf_pkg::entry_t  q_entry,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,  // tx_byte
  output logic                   out_tlast   // last_byte
);
  import mcaf_pkg::*;

  logic                busy_r, busy_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                goal_r, goal_nxt;
  logic [BYTE_W-1:0]   letter_r, letter_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [GOAL_W-1:0]   alt_r, alt_nxt;
  logic [EXP_W-1:0]    exp_r, exp_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  logic [REM_W-1:0]    pow;
  logic [REM_W-1:0]    thr [10];
  logic [3:0]          digit;
  logic                load_out, is_digit;
  logic [BYTE_W-1:0]   byte_val;

  // Multiples of the current power of ten and the digit they bracket.
  assign pow = pow10(exp_r);
  always_comb begin
    digit = '0;
    for (int m = 0; m < 10; m++) begin
      thr[m] = REM_W'(pow * REM_W'(m));
    end
    for (int m = 1; m < 10; m++) begin
      if (rem_r >= thr[m]) begin
        digit = digit + 1'b1;
      end
    end
  end

  // Byte for the current frame position.
  assign is_digit = (pos_r != POS_LETTER) && (goal_r || (pos_r != POS_LAST));
  always_comb begin
    if (pos_r == POS_LETTER) begin
      byte_val = letter_r;
    end else if (is_digit) begin
      byte_val = DIGIT_BASE + BYTE_W'(digit);
    end else begin
      byte_val = CH_NUL;
    end
  end

  assign load_out = busy_r && (!out_valid_r || out_tready);
  assign q_pop    = !q_empty && (!busy_r || (load_out && (pos_r == POS_LAST)));

  // Frame sequencing.
  always_comb begin
    busy_nxt   = busy_r;
    pos_nxt    = pos_r;
    goal_nxt   = goal_r;
    letter_nxt = letter_r;
    rem_nxt    = rem_r;
    alt_nxt    = alt_r;
    exp_nxt    = exp_r;
    if (load_out) begin
      pos_nxt = pos_r + 1'b1;
      if (is_digit) begin
        rem_nxt = rem_r - thr[digit];
        exp_nxt = exp_r - 1'b1;
      end
      // The goal frame moves from x to y after the third digit.
      if (goal_r && (pos_r == POS_GOAL_SPLIT)) begin
        rem_nxt = REM_W'(alt_r);
        exp_nxt = EXP_GOAL;
      end
      if (pos_r == POS_LAST) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt   = 1'b1;
      pos_nxt    = POS_LETTER;
      goal_nxt   = q_entry.goal;
      letter_nxt = q_entry.letter;
      rem_nxt    = q_entry.rem;
      alt_nxt    = q_entry.alt;
      exp_nxt    = q_entry.goal ? EXP_GOAL : EXP_SPEED;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = byte_val;
      out_last_nxt  = (pos_r == POS_LAST);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= POS_LETTER;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    goal_r     <= goal_nxt;
    letter_r   <= letter_nxt;
    rem_r      <= rem_nxt;
    alt_r      <= alt_nxt;
    exp_r      <= exp_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== sv/motion_command_ascii_framer.sv =====
`default_nettype none
// A framing command accepted at the input is written to the queue, loaded by the emitter and
// then registered at the output as its first byte. Frame bytes leave one a cycle through the
// output register while out_tready holds; a command that sends nothing never enters the queue.
// The queue lets the input run ahead of the emitter by QUEUE_DEPTH commands.
// Reset clears both last-sent values to zero, empties the queue and the output.
// ----------------------------------------------------------------------------
// motion_command_ascii_framer
// Frames linear, angular and goal commands as seven-byte ASCII words.
// ----------------------------------------------------------------------------
module motion_command_ascii_framer #(
  parameter int QUEUE_DEPTH = mcaf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // command_value[17:0], goal_x[27:18], goal_y[37:28]
  input  wire logic [1:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // tx_byte
  output logic             out_tlast   // last_byte
);
  import mcaf_pkg::*;

  logic   q_push, q_pop, q_full, q_empty;
  entry_t push_entry, pop_entry;

  // Command classification.
  mcaf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  // Decoupling queue.
  mcaf_queue #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_entry),
    .pop     (q_pop),
    .rd_data (pop_entry),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Byte emitter.
  mcaf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A frame streams without gaps once its bytes are being taken.
  a_frame_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("frame byte missing after a taken non-final byte");

  // The queue is never full and empty at once.
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty together");

  // An accepted goal command always leaves an entry in the queue.
  a_goal_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_GOAL)) |=> !q_empty)
    else $error("goal command was not queued");

endmodule
`default_nettype wire

// ===== sim/tb_motion_command_ascii_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_motion_command_ascii_framer
// Self-checking bench for the ASCII framer. A directed table covers value
// extremes, the digit wrap past five or three places, repeated speed values and
// the unused selector. A random command stream follows. Each byte that comes
// out is compared with a frame predicted from the command and the last values
// sent on the linear and angular channels.
// ----------------------------------------------------------------------------
module tb_motion_command_ascii_framer;
  import mcaf_pkg::*;

  // The selector code that the framer ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int NUM_RANDOM   = 90;
  localparam int IDLE_PCT     = 9;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int FRAME_W      = 7 * BYTE_W;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              last_byte;
  } frame_byte_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [VAL_W-1:0]   value;
    logic [GOAL_W-1:0]  goal_x;
    logic [GOAL_W-1:0]  goal_y;
    bit                 typed;
    bit                 sends;
    logic [FRAME_W-1:0] frame;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // command_value[17:0], goal_x[27:18], goal_y[37:28]
  logic [1:0]  in_tuser;   // op
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // tx_byte
  logic        out_tlast;  // last_byte

  // Predictor state: the last value framed on each speed channel.
  logic [VAL_W-1:0] linear_sent;
  logic [VAL_W-1:0] angular_sent;

  frame_byte_t pending_frame_bytes[$];
  stim_row_t   directed_rows[$];
  int          fail_count = 0;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;

  motion_command_ascii_framer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // One ASCII decimal digit: the digit at place p of v, wrapped to 0..9.
  function automatic logic [BYTE_W-1:0] ascii_digit(input int unsigned v,
                                                    input int unsigned p);
    return DIGIT_BASE + 8'((v / p) % 10);
  endfunction

  // Works out the frame that a command causes and updates the last-sent values.
  task automatic frame_command(input logic [1:0] op, input logic [VAL_W-1:0] value,
                               input logic [GOAL_W-1:0] gx, input logic [GOAL_W-1:0] gy,
                               output bit sends, output logic [FRAME_W-1:0] frame);
    logic              neg;
    logic [VAL_W-1:0]  mag;
    logic [BYTE_W-1:0] letter;
    int unsigned       m;
    int unsigned       x;
    int unsigned       y;
    sends = 1'b0;
    frame = '0;
    x = 32'(gx);
    y = 32'(gy);
    case (op)
      OP_LINEAR, OP_ANGULAR: begin
        if (((op == OP_LINEAR) ? linear_sent : angular_sent) != value) begin
          if (op == OP_LINEAR) linear_sent = value;
          else angular_sent = value;
          neg = value[VAL_W-1];
          mag = neg ? (~value + 1'b1) : value;
          m = 32'(mag);
          if (op == OP_LINEAR) letter = neg ? CH_LIN_NEG : CH_LIN_POS;
          else letter = neg ? CH_ANG_NEG : CH_ANG_POS;
          frame = {letter, ascii_digit(m, 10000), ascii_digit(m, 1000),
                   ascii_digit(m, 100), ascii_digit(m, 10), ascii_digit(m, 1), CH_NUL};
          sends = 1'b1;
        end
      end
      OP_GOAL: begin
        frame = {CH_GOAL, ascii_digit(x, 100), ascii_digit(x, 10), ascii_digit(x, 1),
                 ascii_digit(y, 100), ascii_digit(y, 10), ascii_digit(y, 1)};
        sends = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Appends one row to the directed table; typed rows carry their own frame.
  task automatic table_row(input logic [1:0] op, input logic [VAL_W-1:0] value,
                           input logic [GOAL_W-1:0] gx, input logic [GOAL_W-1:0] gy,
                           input bit typed, input bit sends,
                           input logic [FRAME_W-1:0] frame);
    stim_row_t row;
    row = {op, value, gx, gy, typed, sends, frame};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Random command: speed values often repeat the last one sent or stay small.
  function automatic stim_row_t random_command();
    stim_row_t   row;
    int unsigned sel;
    int          s;
    row = '0;
    sel = $urandom_range(0, 99);
    if (sel < 40) row.op = OP_LINEAR;
    else if (sel < 70) row.op = OP_ANGULAR;
    else if (sel < 92) row.op = OP_GOAL;
    else row.op = OP_UNUSED;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      row.value = (row.op == OP_ANGULAR) ? angular_sent : linear_sent;
    end else if (sel < 35) begin
      s = $urandom_range(0, 40) - 20;
      row.value = s[VAL_W-1:0];
    end else if (sel < 85) begin
      s = $urandom_range(0, 199998) - 99999;
      row.value = s[VAL_W-1:0];
    end else begin
      row.value = VAL_W'($urandom_range(0, (1 << VAL_W) - 1));
    end
    if ($urandom_range(0, 99) < 85) begin
      row.goal_x = GOAL_W'($urandom_range(0, 999));
      row.goal_y = GOAL_W'($urandom_range(0, 999));
    end else begin
      row.goal_x = GOAL_W'($urandom_range(0, 1023));
      row.goal_y = GOAL_W'($urandom_range(0, 1023));
    end
    return row;
  endfunction

  // Offers one command word, waits for the handshake, then records its frame.
  task automatic send_command(input stim_row_t row);
    bit                 sends;
    logic [FRAME_W-1:0] frame;
    frame_byte_t        fb;
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.op;
    in_tdata  <= {2'b00, row.goal_y, row.goal_x, row.value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frame_command(row.op, row.value, row.goal_x, row.goal_y, sends, frame);
    if (row.typed) begin
      sends = row.sends;
      frame = row.frame;
    end
    if (sends) begin
      for (int k = 0; k < 7; k++) begin
        fb.tx_byte   = frame[FRAME_W-1-BYTE_W*k -: BYTE_W];
        fb.last_byte = (k == 6);
        pending_frame_bytes.insert(pending_frame_bytes.size(), fb);
      end
    end
  endtask

  // Stimulus: directed table, then the random stream, then the drain.
  initial begin : stimulus
    stim_row_t row;
    int        sent;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    linear_sent  = '0;
    angular_sent = '0;

    // Unused selector with every bit set: nothing out, no state change.
    table_row(OP_UNUSED,  18'h3FFFF,     10'h3FF, 10'h3FF, 1, 0, '0);
    // Zero equals the value after reset, so no frame.
    table_row(OP_LINEAR,  18'd0,         10'd0,   10'd0,   1, 0, '0);
    table_row(OP_ANGULAR, 18'd0,         10'd0,   10'd0,   1, 0, '0);
    table_row(OP_LINEAR,  18'd99999,     10'd0,   10'd0,   1, 1, {"l99999", CH_NUL});
    // Repeated value is suppressed, whatever the goal fields hold.
    table_row(OP_LINEAR,  18'd99999,     10'h3FF, 10'h3FF, 1, 0, '0);
    table_row(OP_LINEAR,  -18'd99999,    10'd0,   10'd0,   1, 1, {"L99999", CH_NUL});
    table_row(OP_ANGULAR, 18'd1,         10'd0,   10'd0,   1, 1, {"a00001", CH_NUL});
    table_row(OP_ANGULAR, -18'd1,        10'd0,   10'd0,   1, 1, {"A00001", CH_NUL});
    table_row(OP_LINEAR,  18'd0,         10'd0,   10'd0,   1, 1, {"l00000", CH_NUL});
    // Magnitudes past five digits wrap the leading digit.
    table_row(OP_LINEAR,  18'h1FFFF,     10'd0,   10'd0,   1, 1, {"l31071", CH_NUL});
    table_row(OP_LINEAR,  18'h20000,     10'd0,   10'd0,   1, 1, {"L31072", CH_NUL});
    // The unused selector must not touch the linear channel's last value.
    table_row(OP_UNUSED,  18'd5,         10'd0,   10'd0,   1, 0, '0);
    table_row(OP_LINEAR,  18'h20000,     10'd0,   10'd0,   1, 0, '0);
    table_row(OP_ANGULAR, 18'h20000,     10'd0,   10'd0,   1, 1, {"A31072", CH_NUL});
    table_row(OP_ANGULAR, 18'd100000,    10'd0,   10'd0,   1, 1, {"a00000", CH_NUL});
    table_row(OP_GOAL,    18'd0,         10'd0,   10'd0,   1, 1, "G000000");
    table_row(OP_GOAL,    18'h3FFFF,     10'd999, 10'd999, 1, 1, "G999999");
    // Goals past three digits keep only the low three.
    table_row(OP_GOAL,    18'd0,         10'h3FF, 10'h3FF, 1, 1, "G023023");
    table_row(OP_GOAL,    18'd0,         10'd512, 10'd7,   1, 1, "G512007");
    // A repeated goal is always framed.
    table_row(OP_GOAL,    18'd0,         10'd0,   10'd0,   1, 1, "G000000");
    table_row(OP_LINEAR,  18'd12345,     10'h3FF, 10'h3FF, 0, 0, '0);
    table_row(OP_ANGULAR, -18'd54321,    10'd0,   10'd0,   0, 0, '0);
    table_row(OP_UNUSED,  18'd0,         10'd0,   10'd0,   1, 0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_command(directed_rows[i]);

    // Random stream; ignored commands do not count toward the total.
    sent = 0;
    while (sent < NUM_RANDOM) begin
      row = random_command();
      if (row.op != OP_UNUSED) sent++;
      no_idle = (sent >= 45 && sent < 75);
      if (sent == 20) hold_request = 1'b1;
      send_command(row);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, and a stretch with none.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Each accepted byte word is compared with the oldest expected byte.
  always @(posedge clk) begin : check_words
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frame_bytes.size() == 0) begin
        $error("unexpected word: tx_byte %h, last_byte %b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = pending_frame_bytes.pop_front();
        if (out_tdata !== want.tx_byte) begin
          $error("tx_byte: expected %h, actual %h", want.tx_byte, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last_byte) begin
          $error("last_byte: expected %b, actual %b", want.last_byte, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
`default_nettype wire
